// ----- src/dfd_pkg.sv -----
package dfd_pkg;

  localparam int MaxPoints = 256;
  localparam int IdxBits = $clog2(MaxPoints);
  localparam int CntBits = IdxBits + 1;
  localparam int CoordBits = 24;
  localparam int DiffBits = CoordBits + 1;
  localparam int SqBits = 2 * DiffBits;
  localparam int CostBits = SqBits + 1;
  localparam int DistBits = 25;
  localparam int RootBits = (CostBits + 1) / 2;
  localparam int SrcBits = 2 * RootBits;
  localparam int RemBits = CostBits + 2;
  localparam int StepBits = $clog2(RootBits + 1);

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusOverflow = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_QUERY,
    CMD_EMPTY
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t                cmd;
    logic                  first;
    logic                  last;
    logic [IdxBits-1:0]    addr;
    logic [CntBits-1:0]    count;
    logic                  overflow;
    logic [CoordBits-1:0]  x;
    logic [CoordBits-1:0]  y;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_CELL,
    ST_SQRT,
    ST_OUT
  } state_t;

endpackage

// ----- src/discrete_frechet_distance_core.sv -----
// Discrete Frechet distance core. Push reference points (action 0) then query
// points (action 1); a query point with last set yields one result of
// distance and status. Each query point runs read, difference and cell
// update for each column cell, one per stored reference point; the final
// point adds the bit-serial square root and the output register. Reference
// points are stored directly, without the cost steps. A two-entry command
// queue separates the intake from the cost engine; while a result waits to
// be popped, the next query point stalls and the queue fills.
module discrete_frechet_distance_core import dfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 action,
  input  logic [CoordBits-1:0] x,
  input  logic [CoordBits-1:0] y,
  input  logic                 last,
  output logic                 empty,
  input  logic                 pop,
  output logic [DistBits-1:0]  distance,
  output logic [1:0]           status
);

  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  dfd_front u_front (
    .clk, .rst, .push, .full, .action, .x, .y, .last,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  dfd_fifo u_fifo (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
    .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
  );

  dfd_back u_back (
    .clk, .rst,
    .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
    .empty, .pop, .distance, .status
  );

endmodule

// ----- src/dfd_front.sv -----
module dfd_front import dfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 action,
  input  logic [CoordBits-1:0] x,
  input  logic [CoordBits-1:0] y,
  input  logic                 last,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd
);

  logic [CntBits-1:0] ref_count;
  logic               ref_overflow;
  logic               ref_done;
  logic               query_started;
  logic               restart;
  logic [CntBits-1:0] base;
  logic               ovf_base;

  assign full = !cmd_ready;
  assign cmd_valid = push;
  assign restart = !action && (ref_done || query_started);
  assign base = restart ? '0 : ref_count;
  assign ovf_base = restart ? 1'b0 : ref_overflow;

  always_comb begin
    cmd.first = !query_started;
    cmd.last = last;
    cmd.addr = base[IdxBits-1:0];
    cmd.count = base;
    cmd.overflow = ovf_base;
    cmd.x = x;
    cmd.y = y;
    if (!action) begin
      cmd.cmd = CMD_STORE;
    end else if (ref_count == '0) begin
      cmd.cmd = CMD_EMPTY;
    end else begin
      cmd.cmd = CMD_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
      ref_overflow <= 1'b0;
      ref_done <= 1'b0;
      query_started <= 1'b0;
    end else if (push && cmd_ready) begin
      if (!action) begin
        query_started <= 1'b0;
        ref_done <= last;
        if (base < CntBits'(MaxPoints)) begin
          ref_count <= base + 1'b1;
          ref_overflow <= ovf_base;
        end else begin
          ref_count <= base;
          ref_overflow <= 1'b1;
        end
      end else begin
        ref_done <= 1'b1;
        query_started <= (ref_count != '0) && !last;
      end
    end
  end

endmodule

// ----- src/dfd_fifo.sv -----
module dfd_fifo import dfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       wr;
  logic       rd;

  assign in_ready = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_cmd = mem[rp];
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ----- src/dfd_back.sv -----
module dfd_back import dfd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  cmd_t                cmd,
  output logic                empty,
  input  logic                pop,
  output logic [DistBits-1:0] distance,
  output logic [1:0]          status
);

  state_t state, state_next;

  logic [CoordBits-1:0] ref_x [MaxPoints];
  logic [CoordBits-1:0] ref_y [MaxPoints];
  logic [CostBits-1:0]  col [MaxPoints];

  cmd_t                 cur;
  logic [IdxBits-1:0]   j;
  logic [CoordBits-1:0] rx, ry;
  logic [CostBits-1:0]  up;
  logic [CostBits-1:0]  diag;
  logic [CostBits-1:0]  prev;
  logic [SqBits-1:0]    sqa, sqb;
  logic signed [DiffBits-1:0] dx, dy;
  logic [CoordBits-1:0] adx, ady;
  logic [2*CoordBits-1:0] prod_x, prod_y;
  logic [CostBits-1:0]  pc, cell_cost, best;
  logic                 rd_last;
  logic                 ref_wr;

  logic [RemBits-1:0]   sq_rem;
  logic [RemBits-1:0]   sq_cat;
  logic                 sq_ge;
  logic [RootBits+1:0]  sq_try;
  logic [SrcBits-1:0]   sq_src;
  logic [RootBits-1:0]  root;
  logic [StepBits-1:0]  sq_i;

  logic                 out_full;

  assign empty = !out_full;
  assign rd_last = ({1'b0, j} == cur.count - 1'b1);
  assign ref_wr = state == ST_IDLE && cmd_valid && cmd.cmd == CMD_STORE
                  && cmd.count < CntBits'(MaxPoints);

  assign dx = $signed({rx[CoordBits-1], rx}) - $signed({cur.x[CoordBits-1], cur.x});
  assign dy = $signed({ry[CoordBits-1], ry}) - $signed({cur.y[CoordBits-1], cur.y});
  assign adx = dx[DiffBits-1] ? CoordBits'(-dx) : CoordBits'(dx);
  assign ady = dy[DiffBits-1] ? CoordBits'(-dy) : CoordBits'(dy);
  assign prod_x = {{CoordBits{1'b0}}, adx} * {{CoordBits{1'b0}}, adx};
  assign prod_y = {{CoordBits{1'b0}}, ady} * {{CoordBits{1'b0}}, ady};

  assign sq_try = {root, 2'b01};
  assign sq_cat = {sq_rem[RemBits-3:0], sq_src[SrcBits-1 -: 2]};
  assign sq_ge = sq_cat >= RemBits'(sq_try);

  always_ff @(posedge clk) begin
    if (ref_wr) begin
      ref_x[cmd.addr] <= cmd.x;
      ref_y[cmd.addr] <= cmd.y;
    end
    rx <= ref_x[j];
    ry <= ref_y[j];
    up <= col[j];
    if (state == ST_CELL) begin
      col[j] <= cell_cost;
    end
  end

  always_comb begin
    pc = CostBits'(sqa) + CostBits'(sqb);
    best = up;
    if (!cur.first) begin
      if (j != '0) begin
        if (diag < best) best = diag;
        if (prev < best) best = prev;
      end
    end else if (j != '0) begin
      best = prev;
    end else begin
      best = '0;
    end
    cell_cost = (best > pc) ? best : pc;
  end

  always_comb begin
    state_next = state;
    cmd_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.cmd == CMD_STORE) begin
            cmd_ready = 1'b1;
          end else if (cmd.cmd == CMD_EMPTY) begin
            if (!cmd.last) cmd_ready = 1'b1;
            else if (!out_full) begin
              cmd_ready = 1'b1;
            end
          end else begin
            cmd_ready = !out_full;
            if (!out_full) state_next = ST_READ;
          end
        end
      end
      ST_READ: state_next = ST_DIFF;
      ST_DIFF: state_next = ST_CELL;
      ST_CELL: begin
        if (rd_last) state_next = cur.last ? ST_SQRT : ST_IDLE;
        else state_next = ST_READ;
      end
      ST_SQRT: if (sq_i == '0) state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && out_full) out_full <= 1'b0;
      if (state == ST_IDLE && cmd_valid && cmd_ready && cmd.cmd == CMD_EMPTY
          && cmd.last) begin
        out_full <= 1'b1;
      end
      if (state == ST_OUT) out_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && cmd_ready) begin
      cur <= cmd;
      j <= '0;
      if (cmd.cmd == CMD_EMPTY) begin
        distance <= '0;
        status <= StatusEmpty;
      end
    end
    if (state == ST_DIFF) begin
      sqa <= SqBits'(prod_x);
      sqb <= SqBits'(prod_y);
      if (j == '0) diag <= '0;
    end
    if (state == ST_CELL) begin
      prev <= cell_cost;
      diag <= up;
      if (!rd_last) j <= j + 1'b1;
      sq_rem <= '0;
      root <= '0;
      sq_i <= StepBits'(RootBits - 1);
      sq_src <= SrcBits'(cell_cost);
    end
    if (state == ST_SQRT) begin
      sq_src <= sq_src << 2;
      sq_rem <= sq_ge ? sq_cat - RemBits'(sq_try) : sq_cat;
      root <= {root[RootBits-2:0], sq_ge};
      if (sq_i != '0) sq_i <= sq_i - 1'b1;
    end
    if (state == ST_OUT) begin
      distance <= (root > RootBits'({DistBits{1'b1}})) ? {DistBits{1'b1}}
                                                       : DistBits'(root);
      status <= cur.overflow ? StatusOverflow : StatusOk;
    end
  end

endmodule
